// ===== hdl/mrpt_pkg.sv =====
// shared types and constants for the motor ramp position tracker
`timescale 1ns / 1ps

package mrpt_pkg;

    typedef enum logic [2:0] {
        MODE_RAMP_TICK = 3'd0,
        MODE_POS_TICK  = 3'd1,
        MODE_FORWARD   = 3'd2,
        MODE_BACK      = 3'd3,
        MODE_STOP      = 3'd4,
        MODE_SET_SPEED = 3'd5,
        MODE_SAVE_ZERO = 3'd6,
        MODE_SAVE_NINE = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        MOT_STOP = 3'b001,
        MOT_FWD  = 3'b010,
        MOT_BACK = 3'b100
    } t_motion;

    typedef enum logic [2:0] {
        RAMP_STOP = 3'b001,
        RAMP_INC  = 3'b010,
        RAMP_DEC  = 3'b100
    } t_ramp;

    localparam logic [1:0] RUN_STOPPED = 2'd0;
    localparam logic [1:0] RUN_FORWARD = 2'd1;
    localparam logic [1:0] RUN_BACK    = 2'd2;

    localparam logic [1:0] CFG_RELAY_POLARITY = 2'd0;
    localparam logic [1:0] CFG_ACCEL_STEP     = 2'd1;
    localparam logic [1:0] CFG_DEGREE_SPEED   = 2'd2;

    typedef struct packed {
        logic [15:0]        pwm_compare;
        logic               relay_level;
        logic [1:0]         run_state;
        logic signed [31:0] relative_position;
        logic signed [31:0] travel_span;
        logic               zero_mark_valid;
        logic               ninety_mark_valid;
    } t_result;

    typedef struct packed {
        logic        we;
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg_wr;

endpackage

// ===== hdl/mrpt_cmd_if.sv =====
// command beat channel: mode and speed value
`timescale 1ns / 1ps

interface mrpt_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [15:0] speed_value;

    modport source (output valid, output mode, output speed_value, input ready);
    modport sink (input valid, input mode, input speed_value, output ready);
endinterface

// ===== hdl/mrpt_res_if.sv =====
// result beat channel: compare value, relay, state, position and span
`timescale 1ns / 1ps

interface mrpt_res_if;
    logic               valid;
    logic               ready;
    logic [15:0]        pwm_compare;
    logic               relay_level;
    logic [1:0]         run_state;
    logic signed [31:0] relative_position;
    logic signed [31:0] travel_span;
    logic               zero_mark_valid;
    logic               ninety_mark_valid;

    modport source (
        output valid, output pwm_compare, output relay_level, output run_state,
        output relative_position, output travel_span, output zero_mark_valid,
        output ninety_mark_valid, input ready
    );
    modport sink (
        input valid, input pwm_compare, input relay_level, input run_state,
        input relative_position, input travel_span, input zero_mark_valid,
        input ninety_mark_valid, output ready
    );
endinterface

// ===== hdl/mrpt_cfg_if.sv =====
// configuration write channel: register index and data
`timescale 1ns / 1ps

interface mrpt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/mrpt_core.sv =====
// ramp, position and mark state with next-state and result logic
`timescale 1ns / 1ps

module mrpt_core #(
    parameter int unsigned TICK_PERIOD_MS = 100
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [2:0]        i_mode,
    input  logic [15:0]       i_speed,
    input  mrpt_pkg::t_cfg_wr i_cfg,
    output mrpt_pkg::t_result o_result
);
    import mrpt_pkg::*;

    localparam logic [31:0] SPAN_SCALE = 32'(90 * (1000 / TICK_PERIOD_MS));

    logic        r_polarity;
    logic [15:0] r_accel;
    logic [14:0] r_deg;

    logic [15:0] r_cur, n_cur;
    logic [15:0] r_tgt, n_tgt;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_zmark, n_zmark;
    logic [31:0] r_nmark, n_nmark;
    logic        r_zsaved, n_zsaved;
    logic        r_nsaved, n_nsaved;
    t_motion     r_motion, n_motion;
    logic        r_armed, n_armed;
    t_ramp       r_kind, n_kind;
    logic        r_counting, n_counting;
    logic        r_count_back, n_count_back;
    logic        r_relay, n_relay;

    logic [15:0] ss_cur;
    logic        ss_arm;
    t_ramp       ss_kind;
    logic [31:0] span_est;
    logic [31:0] span_now;
    logic [31:0] rel_now;
    logic [1:0]  run_code;

    assign span_est = SPAN_SCALE * {17'd0, r_deg};

    // speed command toward i_speed with one step applied
    always_comb begin
        logic [16:0] sum;
        sum     = '0;
        ss_cur  = r_cur;
        ss_arm  = 1'b0;
        ss_kind = r_kind;
        if (ss_cur != i_speed) begin
            if (ss_cur > i_speed) begin
                ss_cur = (ss_cur > r_accel) ? ss_cur - r_accel : i_speed;
                if (ss_cur != i_speed) begin
                    ss_arm  = 1'b1;
                    ss_kind = RAMP_DEC;
                end
            end
            if (ss_cur < i_speed) begin
                sum    = {1'b0, ss_cur} + {1'b0, r_accel};
                ss_cur = (sum < {1'b0, i_speed}) ? sum[15:0] : i_speed;
                if (ss_cur != i_speed) begin
                    ss_arm  = 1'b1;
                    ss_kind = RAMP_INC;
                end
            end
        end
    end

    always_comb begin
        logic [16:0] sum;
        logic [15:0] dif;
        logic        do_widen;
        sum          = '0;
        dif          = '0;
        do_widen     = 1'b0;
        n_cur        = r_cur;
        n_tgt        = r_tgt;
        n_pos        = r_pos;
        n_zmark      = r_zmark;
        n_nmark      = r_nmark;
        n_zsaved     = r_zsaved;
        n_nsaved     = r_nsaved;
        n_motion     = r_motion;
        n_armed      = r_armed;
        n_kind       = r_kind;
        n_counting   = r_counting;
        n_count_back = r_count_back;
        n_relay      = r_relay;
        unique case (t_mode'(i_mode))
            MODE_RAMP_TICK: begin
                if (r_armed) begin
                    n_armed = 1'b0;
                    case (r_kind)
                        RAMP_STOP: begin
                            n_cur = (r_cur > r_accel) ? r_cur - r_accel : 16'd0;
                            if (n_cur != 16'd0) begin
                                n_armed = 1'b1;
                            end else begin
                                n_counting = 1'b0;
                                do_widen   = 1'b1;
                            end
                        end
                        RAMP_INC: begin
                            sum     = {1'b0, r_cur} + {1'b0, r_accel};
                            n_cur   = (sum < {1'b0, r_tgt}) ? sum[15:0] : r_tgt;
                            n_armed = (n_cur != r_tgt);
                        end
                        RAMP_DEC: begin
                            if (r_cur > r_accel) begin
                                dif   = r_cur - r_accel;
                                n_cur = (dif > r_tgt) ? dif : r_tgt;
                            end else begin
                                n_cur = r_tgt;
                            end
                            n_armed = (n_cur != r_tgt);
                        end
                        default: n_armed = 1'b0;
                    endcase
                end
            end
            MODE_POS_TICK: begin
                if (r_counting) begin
                    n_pos    = r_count_back ? r_pos - {16'd0, r_cur} : r_pos + {16'd0, r_cur};
                    do_widen = 1'b1;
                end
            end
            MODE_FORWARD, MODE_BACK: begin
                n_motion     = (t_mode'(i_mode) == MODE_FORWARD) ? MOT_FWD : MOT_BACK;
                n_relay      = (t_mode'(i_mode) == MODE_FORWARD) ? r_polarity : ~r_polarity;
                n_tgt        = i_speed;
                n_cur        = ss_cur;
                if (ss_arm) begin
                    n_armed = 1'b1;
                    n_kind  = ss_kind;
                end
                n_counting   = 1'b1;
                n_count_back = (t_mode'(i_mode) == MODE_BACK);
            end
            MODE_STOP: begin
                n_relay  = ~r_polarity;
                n_motion = MOT_STOP;
                n_cur    = (r_cur > r_accel) ? r_cur - r_accel : 16'd0;
                if (n_cur != 16'd0) begin
                    n_armed = 1'b1;
                    n_kind  = RAMP_STOP;
                end else begin
                    n_armed    = 1'b0;
                    n_counting = 1'b0;
                    do_widen   = 1'b1;
                end
            end
            MODE_SET_SPEED: begin
                n_tgt = i_speed;
                if (r_motion != MOT_STOP) begin
                    n_cur = ss_cur;
                    if (ss_arm) begin
                        n_armed = 1'b1;
                        n_kind  = ss_kind;
                    end
                end
            end
            MODE_SAVE_ZERO: begin
                n_zsaved = 1'b1;
                n_zmark  = r_pos;
            end
            MODE_SAVE_NINE: begin
                n_nsaved = 1'b1;
                n_nmark  = r_pos;
            end
            default: ;
        endcase
        if (do_widen) begin
            if (n_nsaved && ($signed(n_pos) > $signed(n_nmark))) begin
                n_nmark = n_pos;
            end
            if (n_zsaved && ($signed(n_zmark) > $signed(n_pos))) begin
                n_zmark = n_pos;
            end
        end
    end

    // result from the state after this beat
    always_comb begin
        if (n_zsaved && n_nsaved && ($signed(n_nmark) > $signed(n_zmark))) begin
            span_now = n_nmark - n_zmark;
        end else begin
            span_now = span_est;
        end
        if (n_zsaved) begin
            rel_now = n_pos - n_zmark;
        end else if (n_nsaved) begin
            rel_now = span_now - (n_nmark - n_pos);
        end else begin
            rel_now = '1;
        end
        case (n_motion)
            MOT_FWD:  run_code = RUN_FORWARD;
            MOT_BACK: run_code = RUN_BACK;
            default:  run_code = RUN_STOPPED;
        endcase
    end

    assign o_result.pwm_compare       = n_cur;
    assign o_result.relay_level       = n_relay;
    assign o_result.run_state         = run_code;
    assign o_result.relative_position = $signed(rel_now);
    assign o_result.travel_span       = $signed(span_now);
    assign o_result.zero_mark_valid   = n_zsaved;
    assign o_result.ninety_mark_valid = n_nsaved;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polarity <= 1'b0;
            r_accel    <= '0;
            r_deg      <= '0;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                CFG_RELAY_POLARITY: r_polarity <= i_cfg.data[0];
                CFG_ACCEL_STEP:     r_accel    <= i_cfg.data;
                CFG_DEGREE_SPEED:   r_deg      <= i_cfg.data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur        <= '0;
            r_tgt        <= '0;
            r_pos        <= '0;
            r_zmark      <= '0;
            r_nmark      <= '0;
            r_zsaved     <= 1'b0;
            r_nsaved     <= 1'b0;
            r_motion     <= MOT_STOP;
            r_armed      <= 1'b0;
            r_kind       <= RAMP_STOP;
            r_counting   <= 1'b0;
            r_count_back <= 1'b0;
            r_relay      <= 1'b1;
        end else if (i_fire) begin
            r_cur        <= n_cur;
            r_tgt        <= n_tgt;
            r_pos        <= n_pos;
            r_zmark      <= n_zmark;
            r_nmark      <= n_nmark;
            r_zsaved     <= n_zsaved;
            r_nsaved     <= n_nsaved;
            r_motion     <= n_motion;
            r_armed      <= n_armed;
            r_kind       <= n_kind;
            r_counting   <= n_counting;
            r_count_back <= n_count_back;
            r_relay      <= n_relay;
        end
    end

    a_stop_halts_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (t_mode'(i_mode) == MODE_STOP) |=> (r_motion == MOT_STOP) && !r_relay == r_polarity)
        else $error("stop beat did not stop motion");

    a_zero_mark_saved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (t_mode'(i_mode) == MODE_SAVE_ZERO) |=> r_zsaved && (r_zmark == $past(r_pos)))
        else $error("zero mark not captured");

endmodule

// ===== hdl/mrpt_obuf.sv =====
// two-entry result buffer: output register plus skid slot
`timescale 1ns / 1ps

module mrpt_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mrpt_pkg::t_result i_data,
    output logic              o_space,
    output logic              o_valid,
    output mrpt_pkg::t_result o_data,
    input  logic              i_take
);
    import mrpt_pkg::*;

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    take;

    assign take    = r_main_v && i_take;
    assign o_space = !r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_main_v <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_main_v || take) begin
            r_main_v <= i_load;
        end else if (i_load) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_main <= r_skid;
            end
        end else if (!r_main_v || take) begin
            if (i_load) begin
                r_main <= i_data;
            end
        end else if (i_load) begin
            r_skid <= i_data;
        end
    end

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid slot holds a beat ahead of the output register");

    a_no_load_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !i_load)
        else $error("beat loaded while both slots are full");

endmodule

// ===== hdl/motor_ramp_position_tracker.sv =====
// a result is registered when its command beat is accepted, in the skid slot while the output register is held
// throughput: one command beat per cycle; ready drops only while two results wait
// the result path is a two-entry buffer, so a stalled sink costs one held beat
// reset: synchronous active-low; speed, position, marks and config clear to zero
// after reset the block is stopped, not counting, relay at the inverse of polarity
`timescale 1ns / 1ps

module motor_ramp_position_tracker #(
    parameter int unsigned TICK_PERIOD_MS = 100
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mrpt_cmd_if.sink   i_cmd,
    mrpt_cfg_if.sink   i_cfg,
    mrpt_res_if.source o_res
);
    import mrpt_pkg::*;

    logic    cmd_fire;
    logic    buf_space;
    t_cfg_wr cfg_wr;
    t_result core_res;
    t_result out_res;

    assign i_cmd.ready = buf_space;
    assign cmd_fire    = i_cmd.valid && buf_space;

    assign i_cfg.ready  = 1'b1;
    assign cfg_wr.we    = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;

    mrpt_core #(
        .TICK_PERIOD_MS(TICK_PERIOD_MS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (cmd_fire),
        .i_mode   (i_cmd.mode),
        .i_speed  (i_cmd.speed_value),
        .i_cfg    (cfg_wr),
        .o_result (core_res)
    );

    mrpt_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (cmd_fire),
        .i_data  (core_res),
        .o_space (buf_space),
        .o_valid (o_res.valid),
        .o_data  (out_res),
        .i_take  (o_res.ready)
    );

    assign o_res.pwm_compare       = out_res.pwm_compare;
    assign o_res.relay_level       = out_res.relay_level;
    assign o_res.run_state         = out_res.run_state;
    assign o_res.relative_position = out_res.relative_position;
    assign o_res.travel_span       = out_res.travel_span;
    assign o_res.zero_mark_valid   = out_res.zero_mark_valid;
    assign o_res.ninety_mark_valid = out_res.ninety_mark_valid;

endmodule
